// File: rtl/core/ale_pkg.sv
// Shared types, constants and saturating helpers for the associated Legendre evaluator.
`default_nettype none
package ale_pkg;

	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ORDER = 2'd1,
		ST_ARG   = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	// Right shift applied after a product.
	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_30 = 2'd1,
		SH_31 = 2'd2
	} shift_t;

	// Multiplier states.
	typedef enum logic [1:0] {
		MS_IDLE,
		MS_RUN,
		MS_RND
	} mul_state_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ, S_SQW, S_ROOT,
		S_MA, S_MAW, S_MB, S_MBW,
		S_Q1A, S_Q1AW, S_Q1B, S_Q1BW,
		S_RA, S_RAW, S_RB, S_RBW, S_RC, S_RCW,
		S_DIV, S_FIN
	} state_t;

	typedef struct packed {
		logic   start;
		logic   b_neg;
		shift_t shift;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic clamp;
	} mul_rsp_t;

	// Signed value from magnitude and sign; top bit of the result flags a clamp.
	function automatic logic [64:0] from_mag(input logic [63:0] mg, input logic neg);
		logic [64:0] r;
		if (neg) begin
			if (mg > MIN64) r = {1'b1, MIN64};
			else r = {1'b0, 64'(-mg)};
		end else begin
			if (mg[63]) r = {1'b1, MAX64};
			else r = {1'b0, mg};
		end
		return r;
	endfunction

	// Saturating negation; top bit flags a clamp.
	function automatic logic [64:0] sat_neg(input logic [63:0] v);
		logic [64:0] r;
		if (v == MIN64) r = {1'b1, MAX64};
		else r = {1'b0, 64'(-v)};
		return r;
	endfunction

	// Saturating subtraction a - b; top bit flags a clamp.
	function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] dif;
		logic [64:0] r;
		dif = {a[63], a} - {b[63], b};
		if (dif[64] != dif[63]) r = {1'b1, dif[64] ? MIN64 : MAX64};
		else r = {1'b0, dif[63:0]};
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/associated_legendre_eval_unit.sv
// One word at a time: an accepted word holds busy high until the result strobe,
// while a rejected word gets its strobe without raising busy. Products run on the
// bit-serial multiplier, and the divider yields one quotient bit per cycle.
// Reset clears the sequencer and the result strobe; datapath registers are not reset.
`default_nettype none
module associated_legendre_eval_unit #(
	parameter int MAX_DEGREE    = 8,
	parameter int OUT_FRAC_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  degree,
	input  wire logic signed [4:0]  order,
	input  wire logic signed [31:0] arg,
	output logic             done,
	output logic signed [63:0] value,
	output logic [1:0]       status
);
	import ale_pkg::*;

	state_t      st_q, st_d;
	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	logic [63:0] ma;
	logic [31:0] mb;
	logic [63:0] mres;

	logic [4:0]  d_q, am_q, i_q;
	logic        mneg_q, zneg_q, clamp_q;
	logic [31:0] zmag_q, h_q;
	logic [63:0] p_q, p1_q, t_q, r_q;
	logic [63:0] sx_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic [63:0] dn_q;
	logic [4:0]  drem_q;
	logic [3:0]  dk_q;
	logic        dneg_q;

	logic [31:0] zmag_in;
	logic [4:0]  am_in;
	logic        err_ord, err_arg;
	logic [35:0] rt_t;
	logic [33:0] rt_trial;
	logic        rt_ge;
	logic [5:0]  dv_t;
	logic        dv_ge;
	logic [63:0] q_fin;
	logic [63:0] p2;
	logic [64:0] sn, ss, fin;
	logic [63:0] dmag;
	logic [4:0]  kdiv;
	logic [63:0] one_fx;

	// Decode of an incoming word.
	assign zmag_in = arg[31] ? 32'(-arg) : 32'(arg);
	assign am_in   = order[4] ? 5'(-order) : 5'(order);
	assign err_ord = ({1'b0, degree} > 5'(MAX_DEGREE)) || (am_in > {1'b0, degree});
	assign err_arg = zmag_in > 32'h4000_0000;
	assign one_fx  = 64'd1 << OUT_FRAC_BITS;

	// Square root digit step: two radicand bits per cycle.
	assign rt_t     = {rem_q, sx_q[63:62]};
	assign rt_trial = {root_q, 2'b01};
	assign rt_ge    = rt_t >= {2'b00, rt_trial};

	// Division step: one quotient bit per cycle.
	assign dv_t  = {drem_q, dn_q[63]};
	assign dv_ge = dv_t >= {2'b00, dk_q};
	assign q_fin = {dn_q[62:0], dv_ge};
	assign p2    = dneg_q ? 64'(-q_fin) : q_fin;

	// Saturating helpers on multiplier results and on the final result.
	assign sn   = sat_neg(mres);
	assign ss   = sat_sub(t_q, mres);
	assign dmag = ss[63] ? 64'(-ss[63:0]) : ss[63:0];
	assign kdiv = i_q - am_q;
	assign fin  = (mneg_q && am_q[0]) ? sat_neg(r_q) : {1'b0, r_q};

	ale_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.a      (ma),
		.b_mag  (mb),
		.rsp    (mrsp),
		.res    (mres)
	);

	// Next state and multiplier requests.
	always_comb begin
		st_d       = st_q;
		mreq.start = 1'b0;
		mreq.b_neg = 1'b0;
		mreq.shift = SH_0;
		ma         = p_q;
		mb         = 32'(2 * i_q - 5'd1);
		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					if (err_ord || err_arg) st_d = S_IDLE;
					else if (am_in != 5'd0) st_d = S_SQ;
					else if (degree == 4'd0) st_d = S_FIN;
					else st_d = S_Q1A;
				end
			end
			S_SQ: begin
				mreq.start = 1'b1;
				ma         = {32'd0, zmag_q};
				mb         = zmag_q;
				st_d       = S_SQW;
			end
			S_SQW:  if (mrsp.done) st_d = S_ROOT;
			S_ROOT: if (cnt_q == 6'd31) st_d = S_MA;
			S_MA: begin
				mreq.start = 1'b1;
				st_d       = S_MAW;
			end
			S_MAW: if (mrsp.done) st_d = S_MB;
			S_MB: begin
				mreq.start = 1'b1;
				mreq.shift = SH_31;
				ma         = t_q;
				mb         = h_q;
				st_d       = S_MBW;
			end
			S_MBW: begin
				if (mrsp.done) begin
					if (i_q != am_q) st_d = S_MA;
					else if (d_q == am_q) st_d = S_FIN;
					else st_d = S_Q1A;
				end
			end
			S_Q1A: begin
				mreq.start = 1'b1;
				mb         = 32'({am_q, 1'b1});
				st_d       = S_Q1AW;
			end
			S_Q1AW: if (mrsp.done) st_d = S_Q1B;
			S_Q1B: begin
				mreq.start = 1'b1;
				mreq.shift = SH_30;
				mreq.b_neg = zneg_q;
				ma         = t_q;
				mb         = zmag_q;
				st_d       = S_Q1BW;
			end
			S_Q1BW: begin
				if (mrsp.done) begin
					if (d_q == am_q + 5'd1) st_d = S_FIN;
					else st_d = S_RA;
				end
			end
			S_RA: begin
				mreq.start = 1'b1;
				ma         = p1_q;
				st_d       = S_RAW;
			end
			S_RAW: if (mrsp.done) st_d = S_RB;
			S_RB: begin
				mreq.start = 1'b1;
				mreq.shift = SH_30;
				mreq.b_neg = zneg_q;
				ma         = t_q;
				mb         = zmag_q;
				st_d       = S_RBW;
			end
			S_RBW: if (mrsp.done) st_d = S_RC;
			S_RC: begin
				mreq.start = 1'b1;
				mb         = 32'(i_q + am_q - 5'd1);
				st_d       = S_RCW;
			end
			S_RCW: if (mrsp.done) st_d = S_DIV;
			S_DIV: begin
				if (cnt_q == 6'd63) begin
					if (i_q == d_q) st_d = S_FIN;
					else st_d = S_RA;
				end
			end
			S_FIN:   st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= ((st_q == S_IDLE) && start && (err_ord || err_arg)) || (st_q == S_FIN);
		end
	end

	assign busy = (st_q != S_IDLE);

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				d_q     <= {1'b0, degree};
				am_q    <= am_in;
				mneg_q  <= order[4];
				zmag_q  <= zmag_in;
				zneg_q  <= arg[31];
				p_q     <= one_fx;
				r_q     <= one_fx;
				i_q     <= 5'd1;
				clamp_q <= 1'b0;
				value   <= '0;
				status  <= err_ord ? ST_ORDER : ST_ARG;
			end
			S_SQW: begin
				sx_q   <= 64'((64'd1 << 60) - mres) << 2;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			S_ROOT: begin
				sx_q   <= sx_q << 2;
				rem_q  <= rt_ge ? 34'(rt_t - {2'b00, rt_trial}) : rt_t[33:0];
				root_q <= {root_q[30:0], rt_ge};
				cnt_q  <= cnt_q + 6'd1;
				h_q    <= {root_q[30:0], rt_ge};
			end
			S_MAW, S_Q1AW, S_RAW, S_RBW: begin
				if (mrsp.done) begin
					t_q     <= mres;
					clamp_q <= clamp_q | mrsp.clamp;
				end
			end
			S_MBW: begin
				if (mrsp.done) begin
					p_q     <= sn[63:0];
					r_q     <= sn[63:0];
					clamp_q <= clamp_q | mrsp.clamp | sn[64];
					i_q     <= i_q + 5'd1;
				end
			end
			S_Q1BW: begin
				if (mrsp.done) begin
					p1_q    <= mres;
					r_q     <= mres;
					clamp_q <= clamp_q | mrsp.clamp;
					i_q     <= am_q + 5'd2;
				end
			end
			S_RCW: begin
				if (mrsp.done) begin
					clamp_q <= clamp_q | mrsp.clamp | ss[64];
					dn_q    <= dmag + {60'd0, 1'b0, kdiv[3:1]};
					dneg_q  <= ss[63];
					dk_q    <= kdiv[3:0];
					drem_q  <= '0;
					cnt_q   <= '0;
				end
			end
			S_DIV: begin
				dn_q   <= q_fin;
				drem_q <= dv_ge ? 5'(dv_t - {2'b00, dk_q}) : dv_t[4:0];
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					p_q  <= p1_q;
					p1_q <= p2;
					r_q  <= p2;
					i_q  <= i_q + 5'd1;
				end
			end
			S_FIN: begin
				value  <= fin[63:0];
				status <= (clamp_q || fin[64]) ? ST_SAT : ST_OK;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/ale_mul.sv
// Bit-serial signed multiplier with rounding right shift and saturation.
`default_nettype none
module ale_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ale_pkg::mul_req_t req,
	input  wire logic [63:0]       a,
	input  wire logic [31:0]       b_mag,
	output ale_pkg::mul_rsp_t      rsp,
	output logic [63:0]            res
);
	import ale_pkg::*;

	mul_state_t  st_q, st_d;
	logic [63:0] ma_q;
	logic [31:0] b_q;
	logic [63:0] hi_q;
	logic [31:0] lo_q;
	logic [4:0]  cnt_q;
	logic        neg_q;
	shift_t      sh_q;
	logic        done_q;
	logic        clamp_q;
	logic [64:0] sum;
	logic [96:0] prod_r;
	logic [96:0] shifted;
	logic [64:0] fm;

	// Response flags.
	assign rsp = {done_q, clamp_q};

	// One multiplier bit per cycle: add the multiplicand, then shift right.
	assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, ma_q} : 65'd0);

	// Rounding, shift and saturation on the finished 96-bit product.
	always_comb begin
		prod_r  = {1'b0, hi_q, lo_q};
		shifted = prod_r;
		case (sh_q)
			SH_30: begin
				prod_r  = {1'b0, hi_q, lo_q} + (97'd1 << 29);
				shifted = prod_r >> 30;
			end
			SH_31: begin
				prod_r  = {1'b0, hi_q, lo_q} + (97'd1 << 30);
				shifted = prod_r >> 31;
			end
			default: begin
				prod_r  = {1'b0, hi_q, lo_q};
				shifted = prod_r;
			end
		endcase
		if (|shifted[96:64]) fm = {1'b1, neg_q ? MIN64 : MAX64};
		else fm = from_mag(shifted[63:0], neg_q);
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			MS_IDLE: if (req.start) st_d = MS_RUN;
			MS_RUN:  if (cnt_q == 5'd31) st_d = MS_RND;
			MS_RND:  st_d = MS_IDLE;
			default: st_d = MS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MS_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == MS_RND);
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		case (st_q)
			MS_IDLE: begin
				ma_q  <= a[63] ? 64'(-a) : a;
				b_q   <= b_mag;
				neg_q <= a[63] ^ req.b_neg;
				sh_q  <= req.shift;
				hi_q  <= '0;
				lo_q  <= '0;
				cnt_q <= '0;
			end
			MS_RUN: begin
				hi_q  <= sum[64:1];
				lo_q  <= {sum[0], lo_q[31:1]};
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + 5'd1;
			end
			MS_RND: begin
				res     <= fm[63:0];
				clamp_q <= fm[64];
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: tb/sv/legendre_checker.sv
// Watches the evaluator's command and result channels and checks each result word.
`timescale 1ns / 100ps
module legendre_checker
	import ale_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [3:0]         degree,
	input  wire logic signed [4:0]  order,
	input  wire logic signed [31:0] arg,
	input  wire logic               done,
	input  wire logic signed [63:0] value,
	input  wire logic [1:0]         status,
	output int                      errors,
	output int                      pending,
	output int                      checked
);

	typedef struct {
		logic signed [63:0] value;
		status_t            status;
	} legendre_word_t;

	localparam logic [63:0] ONE_Z = 64'd1 << 30;

	legendre_word_t expected_words[$];
	logic clipped;

	// Magnitude of a signed 64-bit value, as an unsigned number.
	function automatic logic [63:0] magnitude(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Signed value from a magnitude and a sign, clamping at the 64-bit range.
	function automatic logic signed [63:0] signed_of(input logic [63:0] mg, input logic neg);
		if (neg) begin
			if (mg > MIN64) begin
				clipped = 1'b1;
				return MIN64;
			end
			return -mg;
		end
		if (mg[63]) begin
			clipped = 1'b1;
			return MAX64;
		end
		return mg;
	endfunction

	// Product shifted right by sh with rounding half away from zero, saturating.
	function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
			input logic signed [63:0] b, input int sh);
		logic [127:0] prod;
		logic neg;
		neg = (a < 0) != (b < 0);
		prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		if (sh > 0)
			prod = prod + (128'd1 << (sh - 1));
		if ((prod >> (64 + sh)) != 0) begin
			clipped = 1'b1;
			return neg ? MIN64 : MAX64;
		end
		prod = prod >> sh;
		return signed_of(prod[63:0], neg);
	endfunction

	function automatic logic signed [63:0] negate(input logic signed [63:0] v);
		if (v == MIN64) begin
			clipped = 1'b1;
			return MAX64;
		end
		return -v;
	endfunction

	function automatic logic signed [63:0] difference(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] dif;
		dif = 65'(a) - 65'(b);
		if (dif > 65'(signed'(MAX64))) begin
			clipped = 1'b1;
			return MAX64;
		end
		if (dif < 65'(signed'(MIN64))) begin
			clipped = 1'b1;
			return MIN64;
		end
		return dif[63:0];
	endfunction

	// Truncated integer square root, one result bit per pass.
	function automatic logic [63:0] root_of(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Expected result word for one command word.
	function automatic legendre_word_t legendre_of(input logic [3:0] d_in,
			input logic signed [4:0] m_in, input logic signed [31:0] z_in);
		legendre_word_t w;
		int d, m, am, i;
		logic signed [63:0] z, h, p, p1, p2, a, b, res, dif;
		logic [63:0] dm, q;
		d = d_in;
		m = m_in;
		am = m < 0 ? -m : m;
		z = z_in;
		clipped = 1'b0;
		w.value = 0;
		if (d > 8 || am > d) begin
			w.status = ST_ORDER;
			return w;
		end
		if (magnitude(z) > ONE_Z) begin
			w.status = ST_ARG;
			return w;
		end
		p = 64'sd1 <<< 32;
		p2 = 0;
		if (am > 0) begin
			h = root_of(((64'd1 << 60) - magnitude(z) * magnitude(z)) << 2);
			for (i = 1; i <= am; i++)
				p = negate(scaled_product(scaled_product(p, 2 * i - 1, 0), h, 31));
		end
		if (d == am) begin
			res = p;
		end else begin
			p1 = scaled_product(scaled_product(p, 2 * am + 1, 0), z, 30);
			if (d == am + 1) begin
				res = p1;
			end else begin
				// Three-term upward recurrence in the degree.
				for (i = am + 2; i <= d; i++) begin
					a = scaled_product(scaled_product(p1, 2 * i - 1, 0), z, 30);
					b = scaled_product(p, i + am - 1, 0);
					dif = difference(a, b);
					dm = magnitude(dif);
					q = (dm + 64'((i - am) / 2)) / 64'(i - am);
					p2 = signed_of(q, dif < 0);
					p = p1;
					p1 = p2;
				end
				res = p2;
			end
		end
		if (m < 0 && am % 2 == 1)
			res = negate(res);
		w.value = res;
		w.status = clipped ? ST_SAT : ST_OK;
		return w;
	endfunction

	// Record expectations on accepted commands and compare each result word.
	always @(posedge clk or negedge arst_n) begin
		legendre_word_t want;
		if (!arst_n) begin
			errors <= 0;
			checked <= 0;
			pending <= 0;
			expected_words.delete();
		end else begin
			if (start && !busy)
				expected_words.push_back(legendre_of(degree, order, arg));
			if (done) begin
				checked <= checked + 1;
				if (expected_words.size() == 0) begin
					if (errors < 10)
						$display("%0t: result word with none expected: value %h status %0d",
							$time, value, status);
					errors <= errors + 1;
				end else begin
					want = expected_words.pop_front();
					if (value !== want.value || status !== want.status) begin
						if (errors < 10)
							$display("%0t: mismatch: value %h status %0d, wanted %h status %0d",
								$time, value, status, want.value, want.status);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
// Stimulus and verdict for the associated Legendre evaluator.
`timescale 1ns / 100ps
module tb;
	import ale_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic signed [31:0] ONE_Z = 32'sd1 <<< 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [3:0] degree = '0;
	logic signed [4:0] order = '0;
	logic signed [31:0] arg = '0;
	logic busy, done;
	logic signed [63:0] value;
	logic [1:0] status;
	int errors, pending, checked;
	int idle_pct = 0;
	int quiet_cycles = 0;
	int sent = 0;

	always #5 clk = ~clk;

	associated_legendre_eval_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.degree(degree), .order(order), .arg(arg),
		.done(done), .value(value), .status(status)
	);

	legendre_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.degree(degree), .order(order), .arg(arg),
		.done(done), .value(value), .status(status),
		.errors(errors), .pending(pending), .checked(checked)
	);

	// The watchdog ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one command word, with random idle cycles first, until it is taken.
	task automatic send_word(input logic [3:0] d, input logic signed [4:0] m,
			input logic signed [31:0] z);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		degree <= d;
		order <= m;
		arg <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	// Well-formed words mostly, with some arbitrary field values as noise.
	task automatic send_random;
		int d, am;
		logic signed [31:0] z;
		if ($urandom_range(9) == 0) begin
			send_word(4'($urandom), 5'($urandom), $urandom);
		end else begin
			d = $urandom_range(8);
			am = $urandom_range(d);
			case ($urandom_range(9))
				0: z = ONE_Z;
				1: z = -ONE_Z;
				2: z = 32'($urandom_range(255)) - 128;
				default: z = int'($urandom_range(32'h8000_0000)) - ONE_Z;
			endcase
			send_word(4'(d), $urandom_range(1) ? 5'(-am) : 5'(am), z);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int phase, k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: field extremes, the error cases and the end points of z.
		send_word(4'd0, 5'sd0, 32'sd0);
		send_word(4'd8, 5'sd8, 32'sd0);
		send_word(4'd8, -5'sd8, 32'sd0);
		send_word(4'd8, -5'sd7, 32'sd12345678);
		send_word(4'd8, 5'sd0, ONE_Z);
		send_word(4'd8, 5'sd0, -ONE_Z);
		send_word(4'd5, 5'sd3, ONE_Z);
		send_word(4'd5, -5'sd3, -ONE_Z);
		send_word(4'd7, 5'sd1, 32'sd1);
		send_word(4'd3, 5'sd4, 32'sd0);
		send_word(4'd2, -5'sd3, 32'sd0);
		send_word(4'd9, 5'sd0, 32'sd0);
		send_word(4'd15, 5'sd15, 32'h7fff_ffff);
		send_word(4'd15, 5'b1_0000, 32'h8000_0000);
		send_word(4'd4, 5'sd1, ONE_Z + 1);
		send_word(4'd4, 5'sd1, -ONE_Z - 1);
		send_word(4'd6, 5'sd2, 32'h7fff_ffff);
		send_word(4'd6, 5'sd2, 32'h8000_0000);
		send_word(4'd1, -5'sd1, -32'sd536870912);
		send_word(4'd8, 5'sd4, 32'sd760000000);
		drain();

		// Three random phases with different sender idling, each drained.
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = phase == 0 ? 20 : (phase == 1 ? 68 : 0);
			for (k = 0; k < 330; k++)
				send_random();
			drain();
		end

		repeat (100) @(posedge clk);
		$display("tb: %0d command words sent, %0d result words checked, %0d mismatches.",
			sent, checked, errors);
		$display("tb: covered all degrees and orders, error cases and both ends of z.");
		if (errors == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ale_pkg.sv
rtl/core/ale_mul.sv
rtl/core/associated_legendre_eval_unit.sv
tb/sv/legendre_checker.sv
tb/sv/tb.sv
